// ===== hdl/ddo_pkg.sv =====
// Shared widths, constants, types and the arctangent table of the odometry block.
package ddo_pkg;

    // Field and register widths
    localparam int unsigned CNT_W     = 32;
    localparam int unsigned ANG_W     = 16;
    localparam int unsigned POS_W     = 32;
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned CFG_IDX_W = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MM_PER_TICK  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RAD_PER_TICK = 1'b1;

    localparam logic [CFG_W-1:0] MM_PER_TICK_RST  = 20'd136315;
    localparam logic [CFG_W-1:0] RAD_PER_TICK_RST = 20'd2621;

    // Shared multiplier operands and product
    localparam int unsigned MA_W = 42;
    localparam int unsigned MB_W = 21;
    localparam int unsigned MP_W = MA_W + MB_W;

    // Datapath widths
    localparam int unsigned DIFF_W = CNT_W + 1;   // sum or difference of two tick deltas
    localparam int unsigned TRAV_W = 41;          // travel, Q.8 mm
    localparam int unsigned H_W    = 48;          // unwrapped heading, Q3.13
    localparam int unsigned D_W    = 43;          // one position step, Q.8 mm
    localparam int unsigned ACC_W  = 44;          // position plus step before saturation
    localparam int unsigned SC_W   = 18;          // sine or cosine, Q2.14

    // Heading limits, Q3.13
    localparam logic signed [H_W-1:0] H_PI     = 48'sd25736;
    localparam logic signed [H_W-1:0] H_NEG_PI = -48'sd25736;
    localparam logic signed [H_W-1:0] H_TWO_PI = 48'sd51472;
    localparam logic signed [H_W-1:0] H_MIN    = -48'sd25735;

    // Position saturation limits
    localparam logic signed [ACC_W-1:0] ACC_MAX = 44'sd2147483647;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -44'sd2147483648;

    // CORDIC datapath, Q.30
    localparam int unsigned CW        = 34;
    localparam int unsigned STEP_W    = 5;
    localparam int unsigned RED_W     = ANG_W + 1;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [RED_W-1:0] CORD_PI      = 17'sd25736;
    localparam logic signed [RED_W-1:0] CORD_HALF_PI = 17'sd12868;

    // Status of the CORDIC unit toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_cord_stat;

    // Arctangent of 2^-i in Q.30
    function automatic logic signed [CW-1:0] atan_q30(input logic [STEP_W-1:0] idx);
        logic signed [CW-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837830;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hdl/ddo_in_if.sv =====
// Input channel: encoder counts and tilt with a valid/ready handshake.
interface ddo_in_if;
    import ddo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [CNT_W-1:0] left_count;
    logic signed [CNT_W-1:0] right_count;
    logic signed [ANG_W-1:0] tilt;

    modport source (output valid, output left_count, output right_count, output tilt,
                    input ready);
    modport sink   (input valid, input left_count, input right_count, input tilt,
                    output ready);
endinterface

// ===== hdl/ddo_out_if.sv =====
// Output channel: position and heading with a valid/ready handshake.
interface ddo_out_if;
    import ddo_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ANG_W-1:0] heading;

    modport source (output valid, output pos_x, output pos_y, output pos_z, output heading,
                    input ready);
    modport sink   (input valid, input pos_x, input pos_y, input pos_z, input heading,
                    output ready);
endinterface

// ===== hdl/ddo_mul.sv =====
// Shared signed multiplier with a registered product.
module ddo_mul (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [ddo_pkg::MA_W-1:0]  i_a,
    input  logic signed [ddo_pkg::MB_W-1:0]  i_b,
    output logic signed [ddo_pkg::MP_W-1:0]  o_prod
);
    import ddo_pkg::*;

    logic signed [MP_W-1:0] r_prod;

    // Load a new product when the sequencer issues one, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= MP_W'(i_a) * MP_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

// ===== hdl/ddo_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, cosine and sine in Q2.14.
module ddo_cordic #(
    parameter int unsigned STEPS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [ddo_pkg::ANG_W-1:0] i_angle,
    output ddo_pkg::t_cord_stat              o_stat,
    output logic signed [ddo_pkg::SC_W-1:0]  o_cos,
    output logic signed [ddo_pkg::SC_W-1:0]  o_sin
);
    import ddo_pkg::*;

    localparam logic [STEP_W-1:0] LAST = STEP_W'(STEPS - 1);

    typedef enum logic [1:0] {
        C_IDLE,
        C_ROT,
        C_FIN
    } t_cstate;

    t_cstate                r_state;
    logic [STEP_W-1:0]      r_i;
    logic signed [CW-1:0]   r_x;
    logic signed [CW-1:0]   r_y;
    logic signed [CW-1:0]   r_z;
    logic                   r_neg;
    logic                   r_done;
    logic signed [SC_W-1:0] r_cos;
    logic signed [SC_W-1:0] r_sin;

    logic signed [RED_W-1:0] w_ang;
    logic signed [RED_W-1:0] w_red;
    logic                    w_neg;
    logic signed [CW-1:0]    w_xs;
    logic signed [CW-1:0]    w_ys;
    logic signed [CW-1:0]    w_atan;
    logic signed [CW-1:0]    w_xr;
    logic signed [CW-1:0]    w_yr;
    logic signed [SC_W-1:0]  w_c;
    logic signed [SC_W-1:0]  w_s;

    // Fold the angle into [-pi/2, pi/2], remembering to negate the results
    always_comb begin
        w_ang = RED_W'(i_angle);
        w_neg = 1'b0;
        w_red = w_ang;
        if (w_ang > CORD_HALF_PI) begin
            w_red = w_ang - CORD_PI;
            w_neg = 1'b1;
        end else if (w_ang < -CORD_HALF_PI) begin
            w_red = w_ang + CORD_PI;
            w_neg = 1'b1;
        end
    end

    // Shift unit and table lookup for the current micro-rotation
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = atan_q30(r_i);

    // Round Q.30 to Q2.14, halves toward plus infinity
    assign w_xr = r_x + CW'(32768);
    assign w_yr = r_y + CW'(32768);
    assign w_c  = w_xr[CW-1:16];
    assign w_s  = w_yr[CW-1:16];

    // Sequence load, rotations and the final rounding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_done  <= 1'b0;
            r_i     <= '0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= CORDIC_GAIN;
                        r_y     <= '0;
                        r_z     <= CW'(w_red) <<< 17;
                        r_neg   <= w_neg;
                        r_i     <= '0;
                        r_state <= C_ROT;
                    end
                end
                C_ROT: begin
                    if (!r_z[CW-1]) begin
                        r_x <= r_x - w_ys;
                        r_y <= r_y + w_xs;
                        r_z <= r_z - w_atan;
                    end else begin
                        r_x <= r_x + w_ys;
                        r_y <= r_y - w_xs;
                        r_z <= r_z + w_atan;
                    end
                    r_i <= r_i + 1'b1;
                    if (r_i == LAST) begin
                        r_state <= C_FIN;
                    end
                end
                C_FIN: begin
                    r_cos   <= r_neg ? -w_c : w_c;
                    r_sin   <= r_neg ? -w_s : w_s;
                    r_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
        end
    end

    assign o_stat.busy = (r_state != C_IDLE);
    assign o_stat.done = r_done;
    assign o_cos       = r_cos;
    assign o_sin       = r_sin;

endmodule

// ===== hdl/differential_drive_odometry_top.sv =====
// Top level of the differential-drive odometry block: sequencer, state and output register.
//
// Usage:
//   i_item carries absolute left and right encoder counts and a tilt angle (Q3.13 rad).
//   o_result carries the saturating position x, y, z (Q24.8 mm) and the heading (Q3.13).
//   Each transfer on i_item yields exactly one transfer on o_result.
//   Configuration (mm_per_tick at index 0, radians_per_tick at index 1) must be written by the
//   user through i_cfg_we / i_cfg_idx / i_cfg_data while the block is idle; the block does not enforce it.
// Sequencing:
//   The result follows the two passes through the shared CORDIC unit, one micro-rotation
//   per cycle, and then the three products through the shared multiplier. A new item is
//   taken only once the last one has been loaded into the output register.
//   i_item.ready is high only while the sequencer is idle.
// Reset:
//   Synchronous, active low. Previous counts, position, heading and tilt clear to zero;
//   the registers return to their default scale factors.
// Stalls:
//   The result sits in an output register; the block takes the next item while it waits.
//   A second result waits in the sequencer until the first has been transferred.
module differential_drive_odometry_top #(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [ddo_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [ddo_pkg::CFG_W-1:0]          i_cfg_data,
    ddo_in_if.sink                             i_item,
    ddo_out_if.source                          o_result
);
    import ddo_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE,
        S_TRAV,
        S_PHI,
        S_DPHI,
        S_HSUB,
        S_WRAP,
        S_SAT,
        S_CH_GO,
        S_CH_WAIT,
        S_CT_GO,
        S_CT_WAIT,
        S_MX,
        S_DX,
        S_AX,
        S_DY,
        S_AY,
        S_DZ,
        S_AZ,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [CFG_W-1:0]         r_mm;
    logic [CFG_W-1:0]         r_rad;
    logic signed [CNT_W-1:0]  r_prev_left;
    logic signed [CNT_W-1:0]  r_prev_right;
    logic signed [POS_W-1:0]  r_acc_x;
    logic signed [POS_W-1:0]  r_acc_y;
    logic signed [POS_W-1:0]  r_acc_z;
    logic signed [ANG_W-1:0]  r_heading;
    logic signed [ANG_W-1:0]  r_tilt;
    logic signed [ANG_W-1:0]  r_tilt_in;
    logic signed [DIFF_W-1:0] r_sum;
    logic signed [DIFF_W-1:0] r_dif;
    logic signed [TRAV_W-1:0] r_travel;
    logic signed [H_W-1:0]    r_h;
    logic signed [SC_W-1:0]   r_cos;
    logic signed [SC_W-1:0]   r_sin;
    logic signed [SC_W-1:0]   r_sint;
    logic signed [D_W-1:0]    r_d;
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_out_x;
    logic signed [POS_W-1:0]  r_out_y;
    logic signed [POS_W-1:0]  r_out_z;
    logic signed [ANG_W-1:0]  r_out_heading;

    logic signed [CNT_W-1:0]  w_dl;
    logic signed [CNT_W-1:0]  w_dr;
    logic                     w_mul_en;
    logic signed [MA_W-1:0]   w_ma;
    logic signed [MB_W-1:0]   w_mb;
    logic signed [MP_W-1:0]   w_prod;
    logic signed [MP_W-1:0]   w_rnd_trav;
    logic signed [MP_W-1:0]   w_rnd_phi;
    logic signed [MP_W-1:0]   w_rnd_step;
    logic signed [POS_W-1:0]  w_acc_sel;
    logic signed [ACC_W-1:0]  w_acc_sum;
    logic signed [POS_W-1:0]  w_acc_sat;
    logic                     w_cord_start;
    logic signed [ANG_W-1:0]  w_cord_ang;
    t_cord_stat               w_cstat;
    logic signed [SC_W-1:0]   w_cord_cos;
    logic signed [SC_W-1:0]   w_cord_sin;

    // Tick deltas wrap modulo 2^32
    assign w_dl = i_item.left_count - r_prev_left;
    assign w_dr = i_item.right_count - r_prev_right;

    // Operand select for the shared multiplier
    always_comb begin
        w_mul_en = 1'b0;
        w_ma     = MA_W'(r_travel);
        w_mb     = MB_W'(r_cos);
        case (r_state)
            S_TRAV: begin
                w_mul_en = 1'b1;
                w_ma     = MA_W'(r_sum);
                w_mb     = {1'b0, r_mm};
            end
            S_PHI: begin
                w_mul_en = 1'b1;
                w_ma     = MA_W'(r_dif);
                w_mb     = {1'b0, r_rad};
            end
            S_MX: begin
                w_mul_en = 1'b1;
                w_mb     = MB_W'(r_cos);
            end
            S_DX: begin
                w_mul_en = 1'b1;
                w_mb     = MB_W'(r_sin);
            end
            S_DY: begin
                w_mul_en = 1'b1;
                w_mb     = MB_W'(r_sint);
            end
            default: w_mul_en = 1'b0;
        endcase
    end

    ddo_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // Rounding adds ahead of the arithmetic shifts
    assign w_rnd_trav = w_prod + MP_W'(4096);
    assign w_rnd_phi  = w_prod + MP_W'(64);
    assign w_rnd_step = w_prod + MP_W'(8192);

    // Saturating position update
    always_comb begin
        case (r_state)
            S_AX:    w_acc_sel = r_acc_x;
            S_AY:    w_acc_sel = r_acc_y;
            default: w_acc_sel = r_acc_z;
        endcase
        w_acc_sum = ACC_W'(w_acc_sel) + ACC_W'(r_d);
        if (w_acc_sum > ACC_MAX) begin
            w_acc_sat = ACC_MAX[POS_W-1:0];
        end else if (w_acc_sum < ACC_MIN) begin
            w_acc_sat = ACC_MIN[POS_W-1:0];
        end else begin
            w_acc_sat = w_acc_sum[POS_W-1:0];
        end
    end

    assign w_cord_start = (r_state == S_CH_GO) || (r_state == S_CT_GO);
    assign w_cord_ang   = (r_state == S_CH_GO) ? r_heading : r_tilt;

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_cord_start),
        .i_angle (w_cord_ang),
        .o_stat  (w_cstat),
        .o_cos   (w_cord_cos),
        .o_sin   (w_cord_sin)
    );

    // Sequencer, state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mm         <= MM_PER_TICK_RST;
            r_rad        <= RAD_PER_TICK_RST;
            r_prev_left  <= '0;
            r_prev_right <= '0;
            r_acc_x      <= '0;
            r_acc_y      <= '0;
            r_acc_z      <= '0;
            r_heading    <= '0;
            r_tilt       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_MM_PER_TICK:  r_mm  <= i_cfg_data;
                    REG_RAD_PER_TICK: r_rad <= i_cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once transferred, unless the next one loads in its place
            if (o_result.ready && r_out_valid && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_item.valid) begin
                        r_sum        <= DIFF_W'(w_dl) + DIFF_W'(w_dr);
                        r_dif        <= DIFF_W'(w_dl) - DIFF_W'(w_dr);
                        r_prev_left  <= i_item.left_count;
                        r_prev_right <= i_item.right_count;
                        r_tilt_in    <= i_item.tilt;
                        r_state      <= S_TRAV;
                    end
                end
                S_TRAV: r_state <= S_PHI;
                S_PHI: begin
                    r_travel <= w_rnd_trav[TRAV_W+12:13];
                    r_state  <= S_DPHI;
                end
                S_DPHI: begin
                    r_h     <= w_rnd_phi[H_W+6:7];
                    r_state <= S_HSUB;
                end
                S_HSUB: begin
                    r_h     <= H_W'(r_heading) - r_h;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    // Wrap once by a full turn
                    if (r_h > H_PI) begin
                        r_h <= r_h - H_TWO_PI;
                    end else if (r_h <= H_NEG_PI) begin
                        r_h <= r_h + H_TWO_PI;
                    end
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    // Clamp a step too large for one wrap
                    if (r_h > H_PI) begin
                        r_heading <= H_PI[ANG_W-1:0];
                    end else if (r_h < H_MIN) begin
                        r_heading <= H_MIN[ANG_W-1:0];
                    end else begin
                        r_heading <= r_h[ANG_W-1:0];
                    end
                    r_state <= S_CH_GO;
                end
                S_CH_GO: r_state <= S_CH_WAIT;
                S_CH_WAIT: begin
                    if (w_cstat.done) begin
                        r_cos   <= w_cord_cos;
                        r_sin   <= w_cord_sin;
                        r_state <= S_CT_GO;
                    end
                end
                S_CT_GO: r_state <= S_CT_WAIT;
                S_CT_WAIT: begin
                    if (w_cstat.done) begin
                        r_sint  <= w_cord_sin;
                        r_state <= S_MX;
                    end
                end
                S_MX: r_state <= S_DX;
                S_DX: begin
                    r_d     <= w_rnd_step[D_W+13:14];
                    r_state <= S_AX;
                end
                S_AX: begin
                    r_acc_x <= w_acc_sat;
                    r_state <= S_DY;
                end
                S_DY: begin
                    r_d     <= w_rnd_step[D_W+13:14];
                    r_state <= S_AY;
                end
                S_AY: begin
                    r_acc_y <= w_acc_sat;
                    r_state <= S_DZ;
                end
                S_DZ: begin
                    r_d     <= w_rnd_step[D_W+13:14];
                    r_state <= S_AZ;
                end
                S_AZ: begin
                    r_acc_z <= w_acc_sat;
                    r_tilt  <= r_tilt_in;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_result.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_x       <= r_acc_x;
                        r_out_y       <= r_acc_y;
                        r_out_z       <= r_acc_z;
                        r_out_heading <= r_heading;
                        r_state       <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_item.ready     = (r_state == S_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.pos_x   = r_out_x;
    assign o_result.pos_y   = r_out_y;
    assign o_result.pos_z   = r_out_z;
    assign o_result.heading = r_out_heading;

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_item.valid && i_item.ready) |=> !i_item.ready)
        else $error("input taken while an item is in work");

    a_heading_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_heading <= 16'sd25736) && (r_heading >= -16'sd25735))
        else $error("heading outside (-pi, pi]");

    a_cord_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cord_start |-> !w_cstat.busy)
        else $error("CORDIC started while busy");

    a_cord_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cstat.done |-> (r_state == S_CH_WAIT || r_state == S_CT_WAIT))
        else $error("CORDIC result with no waiting step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !o_result.ready) |=> (r_state == S_DONE))
        else $error("result overwritten while output stalled");

endmodule

// ===== bench/tb_differential_drive_odometry_top.sv =====
// Self-checking testbench of the differential-drive odometry block with its own pose predictor.
`timescale 1ns / 100ps

module tb_differential_drive_odometry_top;
    import ddo_pkg::*;

    localparam int  CORDIC_STEPS = 16;
    localparam int  END_WAIT     = 2 * CORDIC_STEPS + 28;
    localparam int  HOLD_LEN     = 300;
    localparam longint Q13_HALF_PI = 12868;
    localparam longint Q13_PI      = 25736;
    localparam longint Q13_TWO_PI  = 51472;
    localparam longint ROT_GAIN_Q30 = 652032874;

    typedef struct packed {
        logic signed [CNT_W-1:0] left;
        logic signed [CNT_W-1:0] right;
        logic signed [ANG_W-1:0] tilt;
    } t_odo_item;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic signed [ANG_W-1:0] heading;
    } t_odo_pose;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    ddo_in_if  item_if ();
    ddo_out_if result_if ();

    differential_drive_odometry_top #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if),
        .o_result   (result_if)
    );

    // Arctangent of 2^-i, Q.30 radians
    longint arctan_q30 [0:15] = '{
        843314857, 497837830, 263043837, 133525159,
        67021687, 33543516, 16775851, 8388437,
        4194283, 2097149, 1048576, 524288,
        262144, 131072, 65536, 32768
    };

    // Tracked configuration and odometry state
    int                      cfg_mm_per_tick;
    int                      cfg_rad_per_tick;
    logic [CNT_W-1:0]        trk_prev_left;
    logic [CNT_W-1:0]        trk_prev_right;
    logic signed [POS_W-1:0] trk_x;
    logic signed [POS_W-1:0] trk_y;
    logic signed [POS_W-1:0] trk_z;
    logic signed [ANG_W-1:0] trk_heading;
    logic signed [ANG_W-1:0] trk_tilt;

    t_odo_item        pending_items [$];
    t_odo_pose        expected_poses [$];
    t_odo_item        offer;
    t_odo_pose        want_pose;
    logic [CNT_W-1:0] gen_left;
    logic [CNT_W-1:0] gen_right;
    bit               item_taken;
    bit               steady;
    bit               hold_request;
    int               hold_count;
    int               errors;

    // Divide by 2^s, rounding halves toward +infinity
    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic signed [POS_W-1:0] clamp_pos(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[POS_W-1:0];
    endfunction

    // Rotation-mode CORDIC: cosine and sine of a Q3.13 angle in Q2.14
    function automatic void sin_cos_q14(input logic signed [ANG_W-1:0] ang,
                                        output longint cos_v, output longint sin_v);
        longint a;
        longint x;
        longint y;
        longint z;
        longint nx;
        bit     flip;
        a    = longint'(ang);
        x    = ROT_GAIN_Q30;
        y    = 0;
        flip = 1'b0;
        // Fold the angle into the half-plane the CORDIC converges on
        if (a > Q13_HALF_PI) begin
            a    = a - Q13_PI;
            flip = 1'b1;
        end else if (a < -Q13_HALF_PI) begin
            a    = a + Q13_PI;
            flip = 1'b1;
        end
        z = a * 131072;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - arctan_q30[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + arctan_q30[i];
            end
            x = nx;
        end
        x     = round_shift(x, 16);
        y     = round_shift(y, 16);
        cos_v = flip ? -x : x;
        sin_v = flip ? -y : y;
    endfunction

    // Advance the tracked pose by one encoder sample and return the new pose
    function automatic t_odo_pose advance_odometry(input t_odo_item it);
        logic [CNT_W-1:0] diff;
        longint           dl;
        longint           dr;
        longint           travel;
        longint           dphi;
        longint           h;
        longint           hc;
        longint           hs;
        longint           tc;
        longint           ts;
        t_odo_pose        pose;
        diff   = it.left - trk_prev_left;
        dl     = longint'($signed(diff));
        diff   = it.right - trk_prev_right;
        dr     = longint'($signed(diff));
        travel = round_shift(longint'(cfg_mm_per_tick) * (dl + dr), 13);
        dphi   = round_shift(longint'(cfg_rad_per_tick) * (dl - dr), 7);

        // Wrap the heading once, then clamp whatever is still out of range
        h = longint'(trk_heading) - dphi;
        if (h > Q13_PI)
            h = h - Q13_TWO_PI;
        else if (h <= -Q13_PI)
            h = h + Q13_TWO_PI;
        if (h > Q13_PI)
            h = Q13_PI;
        if (h < -Q13_PI + 1)
            h = -Q13_PI + 1;
        trk_heading = h[ANG_W-1:0];

        // z uses the tilt stored by the previous sample
        sin_cos_q14(trk_heading, hc, hs);
        sin_cos_q14(trk_tilt, tc, ts);
        trk_x = clamp_pos(longint'(trk_x) + round_shift(travel * hc, 14));
        trk_y = clamp_pos(longint'(trk_y) + round_shift(travel * hs, 14));
        trk_z = clamp_pos(longint'(trk_z) + round_shift(travel * ts, 14));
        trk_tilt       = it.tilt;
        trk_prev_left  = it.left;
        trk_prev_right = it.right;

        pose.pos_x   = trk_x;
        pose.pos_y   = trk_y;
        pose.pos_z   = trk_z;
        pose.heading = trk_heading;
        return pose;
    endfunction

    function automatic void check_field(input string field, input longint want,
                                        input longint got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endfunction

    // Clock
    always #10 i_clk = ~i_clk;

    // Offer the next pending sample once the current one has been transferred
    always @(negedge i_clk) begin
        if (i_rst_n && (!item_if.valid || item_taken)) begin
            item_taken = 1'b0;
            if (pending_items.size() != 0 && (steady || $urandom_range(99) >= 10)) begin
                offer                = pending_items.pop_front();
                item_if.valid       <= 1'b1;
                item_if.left_count  <= offer.left;
                item_if.right_count <= offer.right;
                item_if.tilt        <= offer.tilt;
            end else begin
                item_if.valid <= 1'b0;
            end
        end
    end

    // Drive result ready: random stalls, plus one long hold-off on request
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_count   = HOLD_LEN;
            hold_request = 1'b0;
        end
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (hold_count > 0) begin
            hold_count--;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= steady || ($urandom_range(99) >= 10);
        end
    end

    // Check result transfers, then predict for sample transfers
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            if (expected_poses.size() == 0) begin
                $display("%0t: unexpected result: x %0d y %0d z %0d heading %0d", $time,
                         result_if.pos_x, result_if.pos_y, result_if.pos_z, result_if.heading);
                errors++;
            end else begin
                want_pose = expected_poses.pop_front();
                check_field("pos_x", longint'(want_pose.pos_x), longint'(result_if.pos_x));
                check_field("pos_y", longint'(want_pose.pos_y), longint'(result_if.pos_y));
                check_field("pos_z", longint'(want_pose.pos_z), longint'(result_if.pos_z));
                check_field("heading", longint'(want_pose.heading),
                            longint'(result_if.heading));
            end
        end
        if (i_rst_n && item_if.valid && item_if.ready) begin
            expected_poses.push_back(advance_odometry({item_if.left_count,
                                                       item_if.right_count, item_if.tilt}));
            item_taken = 1'b1;
        end
    end

    task automatic push_item(input logic [CNT_W-1:0] left, input logic [CNT_W-1:0] right,
                             input logic [ANG_W-1:0] tilt);
        pending_items.push_back({left, right, tilt});
        gen_left  = left;
        gen_right = right;
    endtask

    // Queue random samples: mostly smooth motion, some spins, jumps and raw noise
    task automatic queue_random(input int n);
        int               sel;
        int               dl;
        int               dr;
        logic [ANG_W-1:0] tilt;
        for (int k = 0; k < n; k++) begin
            sel = $urandom_range(99);
            if ($urandom_range(99) < 85)
                tilt = ANG_W'(int'($urandom_range(0, 51472)) - 25736);
            else
                tilt = ANG_W'($urandom);
            if (sel < 65) begin
                dl = int'($urandom_range(0, 400)) - 200;
                dr = dl + int'($urandom_range(0, 40)) - 20;
                push_item(gen_left + dl, gen_right + dr, tilt);
            end else if (sel < 80) begin
                dl = int'($urandom_range(0, 40000)) - 20000;
                dr = int'($urandom_range(0, 40000)) - 20000;
                push_item(gen_left + dl, gen_right + dr, tilt);
            end else if (sel < 90) begin
                dl = int'($urandom_range(0, 4000)) - 2000;
                push_item(gen_left + dl, gen_right - dl, tilt);
            end else begin
                push_item($urandom, $urandom, tilt);
            end
        end
    endtask

    // Wait until every sample is transferred and every result has come back
    task automatic drain();
        @(negedge i_clk);
        while (pending_items.size() != 0 || expected_poses.size() != 0
               || item_if.valid || item_taken)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_MM_PER_TICK)
            cfg_mm_per_tick = int'(val);
        else if (idx == REG_RAD_PER_TICK)
            cfg_rad_per_tick = int'(val);
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = REG_MM_PER_TICK;
        i_cfg_data           = '0;
        item_if.valid        = 1'b0;
        item_if.left_count   = '0;
        item_if.right_count  = '0;
        item_if.tilt         = '0;
        result_if.ready      = 1'b0;
        item_taken           = 1'b0;
        steady               = 1'b0;
        hold_request         = 1'b0;
        hold_count           = 0;
        errors               = 0;
        gen_left             = '0;
        gen_right            = '0;
        cfg_mm_per_tick      = int'(MM_PER_TICK_RST);
        cfg_rad_per_tick     = int'(RAD_PER_TICK_RST);
        trk_prev_left        = '0;
        trk_prev_right       = '0;
        trk_x                = '0;
        trk_y                = '0;
        trk_z                = '0;
        trk_heading          = '0;
        trk_tilt             = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: standstill, tilt extremes, big heading steps, rollover, saturation
        push_item(32'd0, 32'd0, 16'sd0);
        push_item(32'd100, 32'd100, 16'sd25736);
        push_item(32'd200, 32'd200, -16'sd25736);
        push_item(32'd300, 32'd300, 16'sd12868);
        push_item(32'd400, 32'd400, 16'sh7FFF);
        push_item(32'd500, 32'd500, 16'sh8000);
        push_item(32'd600, 32'd600, 16'sd0);
        push_item(32'd10600, 32'd600, 16'sd100);
        push_item(32'd600, 32'd20600, -16'sd100);
        push_item(32'd700, 32'd20500, 16'sd0);
        push_item(32'h7FFFFFF0, 32'h7FFFFFF0, 16'sd4000);
        push_item(32'h80000010, 32'h80000010, -16'sd4000);
        push_item(32'h80000000, 32'h7FFFFFFF, 16'sd0);
        push_item(32'hFFFFFFFF, 32'h00000000, 16'sd0);
        push_item(32'h00000001, 32'h80000001, 16'sd0);
        push_item(32'h80000002, 32'h00000002, 16'sd0);
        push_item(32'h00000003, 32'h00000003, 16'sd0);
        drain();

        // Largest scale factors
        write_reg(REG_MM_PER_TICK, 20'hFFFFF);
        write_reg(REG_RAD_PER_TICK, 20'hFFFFF);
        queue_random(150);
        drain();

        // Zero scale factors
        write_reg(REG_MM_PER_TICK, 20'h00000);
        write_reg(REG_RAD_PER_TICK, 20'h00000);
        queue_random(100);
        drain();

        // Random scale factors
        write_reg(REG_MM_PER_TICK, CFG_W'($urandom_range(0, 1048575)));
        write_reg(REG_RAD_PER_TICK, CFG_W'($urandom_range(0, 20000)));
        queue_random(300);
        drain();

        // Smallest nonzero scale factors
        write_reg(REG_MM_PER_TICK, 20'd1);
        write_reg(REG_RAD_PER_TICK, 20'd1);
        queue_random(100);
        drain();

        // Defaults again: no idling and a long result hold-off, then idling back on
        write_reg(REG_MM_PER_TICK, MM_PER_TICK_RST);
        write_reg(REG_RAD_PER_TICK, RAD_PER_TICK_RST);
        steady = 1'b1;
        queue_random(150);
        @(posedge i_clk);
        hold_request = 1'b1;
        drain();
        steady = 1'b0;
        queue_random(200);
        drain();

        repeat (END_WAIT) @(posedge i_clk);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Run limit
    initial begin
        #20_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== differential_drive_odometry_top.f =====
hdl/ddo_pkg.sv
hdl/ddo_in_if.sv
hdl/ddo_out_if.sv
hdl/ddo_mul.sv
hdl/ddo_cordic.sv
hdl/differential_drive_odometry_top.sv
bench/tb_differential_drive_odometry_top.sv
